FILE: hdl/sirs_pkg.sv
// Shared types and constants for the signed integer to radix symbols block.
// No dependencies; every other file in this block imports this package.
`default_nettype none

package sirs_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned SYMBOL_W       = 8;
  localparam int unsigned NUM_SYMBOLS    = 16;
  localparam int unsigned SYM_INDEX_W    = $clog2(NUM_SYMBOLS);
  localparam int unsigned CFG_W          = 64;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned BITS_PER_CYCLE = 8;

  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SYMBOLS_LOW  = 2'd0,
    REG_SYMBOLS_HIGH = 2'd1,
    REG_RADIX_COUNT  = 2'd2
  } cfg_reg_t;

  typedef logic [NUM_SYMBOLS-1:0][SYMBOL_W-1:0] alphabet_t;

  // Configuration as seen by the conversion engine.
  typedef struct packed {
    alphabet_t            alphabet;
    logic [RADIX_W-1:0]   radix;
  } cfg_t;

  // One classified value waiting for conversion.
  typedef struct packed {
    logic                 neg;
    logic [VALUE_W-1:0]   mag;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/sirs_if.sv
// Handshake channel interfaces: the value word in and the symbol word out.
// Depends on sirs_pkg for field widths.
`default_nettype none

interface sirs_value_if import sirs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirs_symbol_if import sirs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SYMBOL_W-1:0]   symbol;
  logic                  last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sirs_front.sv
// Front end: configuration registers, alphabet check, value classification.
// Depends on sirs_pkg and sirs_value_if.
`default_nettype none

module sirs_front import sirs_pkg::*; #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  sirs_value_if.sink                   item,
  output job_t                         job,
  output logic                         job_valid,
  input  wire logic                    job_ready,
  output cfg_t                         cfg
);

  alphabet_t           alphabet;
  alphabet_t           alphabet_next;
  logic [RADIX_W-1:0]  radix;
  logic [RADIX_W-1:0]  radix_next;
  logic                alpha_ok;
  logic [VALUE_W-1:0]  raw;
  logic                neg;

  // Radix in range, no zero, plus or minus symbol, no repeated symbol.
  function automatic logic check_alphabet(alphabet_t a, logic [RADIX_W-1:0] n);
    logic ok;
    ok = (n >= RADIX_W'(2)) && (n <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (RADIX_W'(i) < n) begin
        if (a[i] == '0 || a[i] == SYM_PLUS || a[i] == SYM_MINUS) begin
          ok = 1'b0;
        end
      end
      for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
        if (RADIX_W'(j) < n && a[i] == a[j]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  always_comb begin
    alphabet_next = alphabet;
    radix_next    = radix;
    if (cfg_we) begin
      case (cfg_index)
        REG_SYMBOLS_LOW:  alphabet_next[NUM_SYMBOLS/2-1:0]           = cfg_data;
        REG_SYMBOLS_HIGH: alphabet_next[NUM_SYMBOLS-1:NUM_SYMBOLS/2] = cfg_data;
        REG_RADIX_COUNT:  radix_next = cfg_data[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Check against the incoming configuration so the flag is current
  // on the cycle right after a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet <= '0;
      radix    <= '0;
      alpha_ok <= 1'b0;
    end else begin
      alphabet <= alphabet_next;
      radix    <= radix_next;
      alpha_ok <= check_alphabet(alphabet_next, radix_next);
    end
  end

  assign raw = item.value;
  assign neg = raw[VALUE_W-1];

  // Drop every word while the alphabet is bad; otherwise hand it on.
  assign job.neg    = neg;
  assign job.mag    = neg ? (~raw + VALUE_W'(1)) : raw;
  assign job_valid  = item.valid & alpha_ok;
  assign item.ready = job_ready | ~alpha_ok;

  assign cfg.alphabet = alphabet;
  assign cfg.radix    = radix;

endmodule

`default_nettype wire

FILE: hdl/sirs_queue.sv
// Small FIFO of classified values between the front end and the engine.
// Depends on sirs_pkg.
`default_nettype none

module sirs_queue import sirs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  in_job,
  input  wire logic  in_valid,
  output logic       in_ready,
  output job_t       out_job,
  output logic       out_valid,
  input  wire logic  out_ready
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sirs_back.sv
// Conversion engine: iterative divider, digit stack and output register.
// Depends on sirs_pkg and sirs_symbol_if.
`default_nettype none

module sirs_back import sirs_pkg::*; #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire job_t  job,
  input  wire logic  job_valid,
  output logic       job_ready,
  sirs_symbol_if.source result
);

  localparam int unsigned DIGIT_W    = $clog2(MAX_RADIX);
  localparam int unsigned REM_W      = DIGIT_W + 1;
  localparam int unsigned MAX_DIGITS = VALUE_W;
  localparam int unsigned ND_W       = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SP_W       = $clog2(MAX_DIGITS);
  localparam int unsigned STEPS      = VALUE_W / BITS_PER_CYCLE;
  localparam int unsigned STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

  back_state_t          state;
  back_state_t          state_next;
  logic                 neg;
  logic [VALUE_W-1:0]   quo;
  logic [DIGIT_W-1:0]   rem;
  logic [STEP_W-1:0]    step;
  logic [ND_W-1:0]      nd;
  logic [ND_W-1:0]      nd_inc;
  logic [ND_W-1:0]      nd_dec;
  logic [DIGIT_W-1:0]   digits [MAX_DIGITS];

  logic [REM_W-1:0]     radix;
  logic [REM_W-1:0]     div_rem;
  logic [VALUE_W-1:0]   div_quo;
  logic                 last_step;
  logic                 div_done;

  logic                 slot_free;
  logic                 load_job;
  logic                 div_run;
  logic                 load_sign;
  logic                 load_digit;
  logic [DIGIT_W-1:0]   cur_digit;
  logic [SYM_INDEX_W-1:0] sym_index;

  logic                 out_valid;
  logic [SYMBOL_W-1:0]  out_symbol;
  logic                 out_last;

  assign radix = cfg.radix[REM_W-1:0];

  // Restoring division, one quotient bit per inner step.
  always_comb begin
    div_rem = REM_W'(rem);
    div_quo = quo;
    for (int b = 0; b < BITS_PER_CYCLE; b++) begin
      div_rem = {div_rem[DIGIT_W-1:0], div_quo[VALUE_W-1]};
      div_quo = {div_quo[VALUE_W-2:0], 1'b0};
      if (div_rem >= radix) begin
        div_rem    = div_rem - radix;
        div_quo[0] = 1'b1;
      end
    end
  end

  assign last_step = (step == STEP_W'(STEPS - 1));
  assign nd_inc    = nd + ND_W'(1);
  assign nd_dec    = nd - ND_W'(1);
  assign div_done  = last_step && (div_quo == '0 || nd_inc == ND_W'(MAX_DIGITS));
  assign slot_free = ~out_valid | result.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (job_valid) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = neg ? ST_SIGN : ST_EMIT;
      ST_SIGN:   if (slot_free) state_next = ST_EMIT;
      ST_EMIT:   if (slot_free && nd == ND_W'(1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready  = 1'b0;
    load_job   = 1'b0;
    div_run    = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state)
      ST_IDLE: begin
        job_ready = 1'b1;
        load_job  = job_valid;
      end
      ST_DIVIDE: div_run    = 1'b1;
      ST_SIGN:   load_sign  = slot_free;
      ST_EMIT:   load_digit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      nd        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_job) begin
        step <= '0;
        nd   <= '0;
      end else if (div_run) begin
        step <= last_step ? '0 : step + STEP_W'(1);
        if (last_step) begin
          nd <= nd_inc;
        end
      end else if (load_digit) begin
        nd <= nd_dec;
      end
      if (load_sign || load_digit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cur_digit = digits[nd_dec[SP_W-1:0]];
  assign sym_index = SYM_INDEX_W'(cur_digit);

  always_ff @(posedge clk) begin
    if (load_job) begin
      neg <= job.neg;
      quo <= job.mag;
      rem <= '0;
    end else if (div_run) begin
      quo <= div_quo;
      rem <= last_step ? '0 : div_rem[DIGIT_W-1:0];
      if (last_step) begin
        digits[nd[SP_W-1:0]] <= div_rem[DIGIT_W-1:0];
      end
    end
    if (load_sign) begin
      out_symbol <= SYM_MINUS;
      out_last   <= 1'b0;
    end else if (load_digit) begin
      out_symbol <= cfg.alphabet[sym_index];
      out_last   <= (nd == ND_W'(1));
    end
  end

  assign result.valid  = out_valid;
  assign result.symbol = out_symbol;
  assign result.last   = out_last;

endmodule

`default_nettype wire

FILE: hdl/signed_integer_to_radix_symbols_core.sv
// Top level of the signed integer to radix symbols block.
// Depends on sirs_pkg, sirs_if, sirs_front, sirs_queue and sirs_back.
`default_nettype none

// Each 32-bit two's complement value word on item comes out on result as
// a run of symbol words, most significant digit first, preceded by the
// minus symbol when the value is negative; the final word of the run has
// last set. Digits are written in the radix radix_count (2 up to
// MAX_RADIX) using the alphabet held in symbols_low and symbols_high. A
// bad alphabet (radix out of range, a zero, plus or minus symbol among the
// symbols in use, or a repeated symbol) makes the block take value words
// and drop them without output. Write configuration only while idle; a
// write takes effect for a value word presented on the next cycle.
// The conversion engine picks up a value, divides out each digit in the shared
// divider (eight quotient bits per cycle over the 32-bit magnitude), then loads
// the output register with the minus sign, if any, and with each digit symbol
// in turn as the output takes them. A two-word queue lets the input side keep
// taking words while the engine is busy, and the output register lets the
// engine start the next value while the last symbol waits to be taken.
module signed_integer_to_radix_symbols_core import sirs_pkg::*; #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  sirs_value_if.sink                   item,
  sirs_symbol_if.source                result
);

  // Classified value words between front end and queue.
  job_t  front_job;
  logic  front_valid;
  logic  front_ready;

  // Queue head toward the engine.
  job_t  queue_job;
  logic  queue_valid;
  logic  queue_ready;

  // Live configuration; hold steady while any word is in flight.
  cfg_t  cfg;

  // Own the registers, check the alphabet, drop words when it is bad.
  sirs_front #(
    .MAX_RADIX (MAX_RADIX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .cfg       (cfg)
  );

  // Decouple intake from the long conversion.
  sirs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_job    (front_job),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_job   (queue_job),
    .out_valid (queue_valid),
    .out_ready (queue_ready)
  );

  // Divide out digits, stack them, then emit sign and digits in reverse.
  sirs_back #(
    .MAX_RADIX (MAX_RADIX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (queue_job),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .result    (result)
  );

endmodule

`default_nettype wire
